FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/frl_pkg.sv
package frl_pkg;
    localparam int RING_DEPTH      = 1024;
    localparam int ADDR_W          = $clog2(RING_DEPTH);
    localparam int FILL_W          = 11;
    localparam int MAX_CHANNELS    = 2;
    localparam int MAX_PULL_FRAMES = 16;
    localparam int SAMPLE_BITS     = 24;
    localparam int FRAME_W         = SAMPLE_BITS * MAX_CHANNELS;
    localparam int RATIO_W         = 20;
    localparam int PHASE_W         = 24;
    localparam int POS_W           = 25;
    localparam int CNT_W           = 32;
    localparam int NFR_W           = 5;
    localparam int FRAC_W          = 16;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_TARGET   = 2'd1;
    localparam logic [1:0] CFG_CHANNELS = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
endpackage

FILE: rtl/core/frl_ram.sv
module frl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/frl_interp.sv
module frl_interp (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  frl_pkg::t_sample            i_a,
    input  frl_pkg::t_sample            i_b,
    input  logic [frl_pkg::FRAC_W-1:0]  i_frac,
    output frl_pkg::t_sample            o_sample
);
    localparam int DW = frl_pkg::SAMPLE_BITS + 1;
    localparam int MW = DW + frl_pkg::FRAC_W + 1;

    frl_pkg::t_sample     r_a;
    logic signed [MW-1:0] r_mul;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] sum;

    assign diff = DW'(i_b) - DW'(i_a);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a   <= i_a;
            r_mul <= diff * $signed({1'b0, i_frac});
        end
    end

    // The arithmetic shift rounds toward minus infinity.
    assign sum      = DW'(r_a) + r_mul[frl_pkg::FRAC_W +: DW];
    assign o_sample = sum[frl_pkg::SAMPLE_BITS-1:0];
endmodule

FILE: rtl/core/fifo_linear_resampler.sv
// Frame FIFO with a linear-interpolation rate converter on its read side.
// Input channel (i_in_valid / o_in_stall): a push request stores one frame,
// a pull request asks for frame_count output frames at a Q4.16 ratio.
// Output channel (o_out_valid / i_out_stall): a push gives one acknowledgement;
// a pull gives min(frame_count, 16) * channels samples (one if frame_count is zero),
// with o_last on the final one. Every result carries the fill level, target
// level and the overrun and underrun counters after the request.
// A push gives its acknowledgement in the cycle after it is accepted. A pull
// sizes the request (S_CALC, S_CHECK), scans the usable frames (S_SCAN) and
// commits (S_COMMIT); then each interpolated frame is read from the ring
// (S_RDA, S_RDB, S_LATB) and each of its channels goes through the shared
// multiplier (S_MUL) to S_EMIT, while each zero-filled sample takes S_EMIT
// alone. The single ring read port and the shared multiplier keep this serial.
// Input stalls in reset, during a pull, on a stalled result or a register write.
// Reset clears pointers, fill level, phase and counters; ring contents stay
// undefined until written. A stall on the output holds the sequencer in
// S_EMIT until the pending result is taken.
module fifo_linear_resampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [frl_pkg::FILL_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  frl_pkg::t_sample              i_sample_0,
    input  frl_pkg::t_sample              i_sample_1,
    input  logic [frl_pkg::NFR_W-1:0]     i_frame_count,
    input  logic [frl_pkg::RATIO_W-1:0]   i_ratio,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic                          o_accepted,
    output frl_pkg::t_sample              o_out_sample,
    output logic                          o_channel,
    output logic                          o_interpolated,
    output logic [frl_pkg::NFR_W-1:0]     o_frames_produced,
    output logic [frl_pkg::FILL_W-1:0]    o_fill_level,
    output logic [frl_pkg::FILL_W-1:0]    o_target_level,
    output logic [frl_pkg::CNT_W-1:0]     o_overrun_count,
    output logic [frl_pkg::CNT_W-1:0]     o_underrun_count,
    output logic                          o_last
);
    localparam int AW = frl_pkg::ADDR_W;
    localparam int FW = frl_pkg::FILL_W;
    localparam int PW = frl_pkg::POS_W;
    localparam int NW = frl_pkg::NFR_W;
    localparam int LW = FW + frl_pkg::FRAC_W;
    localparam int SB = frl_pkg::SAMPLE_BITS;
    localparam int CW = frl_pkg::CNT_W;
    localparam int NRW = frl_pkg::RATIO_W + NW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CALC   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_COMMIT = 4'd4;
    localparam logic [3:0] S_RDA    = 4'd5;
    localparam logic [3:0] S_RDB    = 4'd6;
    localparam logic [3:0] S_LATB   = 4'd7;
    localparam logic [3:0] S_MUL    = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]                   r_state;
    logic [FW-1:0]                r_cap, r_tgt, r_stored, r_rd;
    logic [1:0]                   r_chs;
    logic [AW-1:0]                r_rp, r_wp, r_base;
    logic [frl_pkg::PHASE_W-1:0]  r_phase;
    logic [frl_pkg::CNT_W-1:0]    r_ovr, r_und;
    logic [NW-1:0]                r_n, r_prod, r_f;
    logic [frl_pkg::RATIO_W-1:0]  r_ratio;
    logic [PW-1:0]                r_endp, r_pos, r_fpos;
    logic                         r_ok, r_c, r_ip;
    logic [frl_pkg::FRAME_W-1:0]  r_fa, r_fb;

    logic                         r_out_valid, r_kind, r_acc, r_ch, r_interp, r_last;
    frl_pkg::t_sample             r_sample;
    logic [NW-1:0]                r_oprod;
    logic [FW-1:0]                r_ofill, r_otgt;
    logic [frl_pkg::CNT_W-1:0]    r_oovr, r_ound;

    logic                         out_free, in_acc, cfg_wr, out_load;
    logic [FW-1:0]                tgt_level, n_cap, sum_p, addr_p, off, n_rp_sum, need, consume;
    logic [FW-1:0]                n_wp;
    logic [1:0]                   n_chs;
    logic [frl_pkg::RATIO_W+NW-1:0] nr;
    logic [LW-1:0]                limit;
    logic [PW-1:0]                pos_ratio;
    logic                         scan_go, last_res, last_ch;
    logic [frl_pkg::FRAME_W-1:0]  rdata;
    frl_pkg::t_sample             ia, ib, isample;

    assign out_free    = !r_out_valid || !i_out_stall;
    // A register write takes the cycle, so no request is taken beside it.
    assign o_in_stall  = !i_rst_n || i_cfg_valid || !((r_state == S_IDLE) && out_free);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = i_rst_n;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign tgt_level   = (r_tgt < r_cap) ? r_tgt : r_cap;
    assign out_load    = (in_acc && (i_req_type == frl_pkg::REQ_PUSH)) ||
                         (!cfg_wr && (r_state == S_EMIT) && out_free);

    always_comb begin
        if (i_cfg_data < FW'(2)) begin
            n_cap = FW'(2);
        end else if (i_cfg_data > FW'(frl_pkg::RING_DEPTH)) begin
            n_cap = FW'(frl_pkg::RING_DEPTH);
        end else begin
            n_cap = i_cfg_data;
        end
        if (i_cfg_data[1:0] == 2'd0) begin
            n_chs = 2'd1;
        end else if (i_cfg_data[1:0] > 2'(frl_pkg::MAX_CHANNELS)) begin
            n_chs = 2'(frl_pkg::MAX_CHANNELS);
        end else begin
            n_chs = i_cfg_data[1:0];
        end
    end

    // Ring address for the current frame (first read) or its successor.
    assign off    = FW'(r_fpos[PW-1:frl_pkg::FRAC_W]) + ((r_state == S_RDB) ? FW'(1) : FW'(0));
    assign sum_p  = FW'(r_base) + off;
    assign addr_p = (sum_p >= r_cap) ? sum_p - r_cap : sum_p;

    assign n_wp     = FW'(r_wp) + FW'(1);
    assign nr       = NRW'(r_n) * NRW'(r_ratio);
    assign need     = FW'(r_endp[PW-1:frl_pkg::FRAC_W]) + FW'(2);
    assign limit    = {r_rd - FW'(1), {frl_pkg::FRAC_W{1'b0}}};
    assign scan_go  = (r_prod < r_n) && (LW'(r_pos) < limit);
    assign pos_ratio = PW'(r_ratio);
    assign consume  = (FW'(r_pos[PW-1:frl_pkg::FRAC_W]) > r_rd) ? r_rd
                                                              : FW'(r_pos[PW-1:frl_pkg::FRAC_W]);
    assign n_rp_sum = FW'(r_rp) + consume;

    assign last_ch  = (r_chs == 2'd1) || r_c;
    assign last_res = (r_n == '0) || ((r_f == r_n - NW'(1)) && last_ch);

    assign ia = r_c ? r_fa[SB +: SB] : r_fa[0 +: SB];
    assign ib = r_c ? r_fb[SB +: SB] : r_fb[0 +: SB];

    frl_ram #(.WIDTH(frl_pkg::FRAME_W), .DEPTH(frl_pkg::RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_req_type == frl_pkg::REQ_PUSH) && (r_stored < r_cap)),
        .i_waddr (r_wp),
        .i_wdata ({i_sample_1, i_sample_0}),
        .i_raddr (addr_p[AW-1:0]),
        .o_rdata (rdata)
    );

    frl_interp u_interp (
        .i_clk    (i_clk),
        .i_load   (r_state == S_MUL),
        .i_a      (ia),
        .i_b      (ib),
        .i_frac   (r_fpos[frl_pkg::FRAC_W-1:0]),
        .o_sample (isample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= FW'(frl_pkg::RING_DEPTH);
            r_tgt       <= '0;
            r_chs       <= 2'(frl_pkg::MAX_CHANNELS);
            r_rp        <= '0;
            r_wp        <= '0;
            r_stored    <= '0;
            r_phase     <= '0;
            r_ovr       <= '0;
            r_und       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free && !out_load) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    frl_pkg::CFG_CAPACITY: r_cap <= n_cap;
                    frl_pkg::CFG_TARGET:   r_tgt <= i_cfg_data;
                    frl_pkg::CFG_CHANNELS: r_chs <= n_chs;
                    default: ;
                endcase
                if (i_cfg_index == frl_pkg::CFG_CAPACITY ||
                    i_cfg_index == frl_pkg::CFG_CHANNELS) begin
                    r_rp     <= '0;
                    r_wp     <= '0;
                    r_stored <= '0;
                    r_phase  <= '0;
                    r_ovr    <= '0;
                    r_und    <= '0;
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_acc && (i_req_type == frl_pkg::REQ_PUSH)) begin
                            r_out_valid <= 1'b1;
                            r_kind      <= frl_pkg::REQ_PUSH;
                            r_sample    <= '0;
                            r_ch        <= 1'b0;
                            r_interp    <= 1'b0;
                            r_oprod     <= '0;
                            r_otgt      <= tgt_level;
                            r_ound      <= r_und;
                            r_last      <= 1'b1;
                            if (r_stored < r_cap) begin
                                r_acc    <= 1'b1;
                                r_wp     <= (n_wp >= r_cap) ? '0 : n_wp[AW-1:0];
                                r_stored <= r_stored + FW'(1);
                                r_ofill  <= r_stored + FW'(1);
                                r_oovr   <= r_ovr;
                            end else begin
                                r_acc   <= 1'b0;
                                r_ovr   <= r_ovr + CW'(1);
                                r_ofill <= r_stored;
                                r_oovr  <= r_ovr + CW'(1);
                            end
                        end else if (in_acc) begin
                            r_n     <= (i_frame_count > NW'(frl_pkg::MAX_PULL_FRAMES))
                                       ? NW'(frl_pkg::MAX_PULL_FRAMES) : i_frame_count;
                            r_ratio <= i_ratio;
                            r_state <= S_CALC;
                        end
                    end
                    S_CALC: begin
                        r_endp  <= PW'(r_phase) + PW'(nr);
                        r_fpos  <= PW'(r_phase);
                        r_pos   <= PW'(r_phase);
                        r_prod  <= '0;
                        r_base  <= r_rp;
                        r_state <= S_CHECK;
                    end
                    S_CHECK: begin
                        // Frames readable: needed span, clamped to capacity and fill.
                        if ((need > r_cap ? r_cap : need) < r_stored) begin
                            r_rd <= (need > r_cap) ? r_cap : need;
                            r_ok <= (r_ratio != '0) && (((need > r_cap) ? r_cap : need) >= FW'(2));
                            r_state <= ((r_ratio != '0) && (((need > r_cap) ? r_cap : need)
                                        >= FW'(2))) ? S_SCAN : S_COMMIT;
                        end else begin
                            r_rd <= r_stored;
                            r_ok <= (r_ratio != '0) && (r_stored >= FW'(2));
                            r_state <= ((r_ratio != '0) && (r_stored >= FW'(2)))
                                       ? S_SCAN : S_COMMIT;
                        end
                    end
                    S_SCAN: begin
                        if (scan_go) begin
                            r_prod <= r_prod + NW'(1);
                            r_pos  <= r_pos + pos_ratio;
                        end else begin
                            r_state <= S_COMMIT;
                        end
                    end
                    S_COMMIT: begin
                        if (!r_ok) begin
                            r_und <= r_und + CW'(1);
                        end else begin
                            if (r_prod < r_n) begin
                                r_und <= r_und + CW'(1);
                            end
                            r_rp     <= (n_rp_sum >= r_cap) ? AW'(n_rp_sum - r_cap)
                                                            : n_rp_sum[AW-1:0];
                            r_stored <= r_stored - consume;
                            r_phase  <= 24'(r_pos - {consume[PW-frl_pkg::FRAC_W-1:0],
                                                     {frl_pkg::FRAC_W{1'b0}}});
                        end
                        r_f     <= '0;
                        r_c     <= 1'b0;
                        r_ip    <= (r_prod != '0);
                        r_state <= (r_prod != '0) ? S_RDA : S_EMIT;
                    end
                    S_RDA: r_state <= S_RDB;
                    S_RDB: begin
                        r_fa    <= rdata;
                        r_state <= S_LATB;
                    end
                    S_LATB: begin
                        r_fb    <= rdata;
                        r_state <= S_MUL;
                    end
                    S_MUL: r_state <= S_EMIT;
                    S_EMIT: begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_kind      <= frl_pkg::REQ_PULL;
                            r_acc       <= 1'b0;
                            r_sample    <= r_ip ? isample : '0;
                            r_ch        <= r_c;
                            r_interp    <= r_ip;
                            r_oprod     <= last_res ? r_prod : '0;
                            r_ofill     <= r_stored;
                            r_otgt      <= tgt_level;
                            r_oovr      <= r_ovr;
                            r_ound      <= r_und;
                            r_last      <= last_res;
                            if (last_res) begin
                                r_state <= S_IDLE;
                            end else if (!last_ch) begin
                                r_c     <= 1'b1;
                                r_state <= r_ip ? S_MUL : S_EMIT;
                            end else begin
                                r_c    <= 1'b0;
                                r_f    <= r_f + NW'(1);
                                r_fpos <= r_fpos + pos_ratio;
                                r_ip   <= (r_f + NW'(1)) < r_prod;
                                r_state <= ((r_f + NW'(1)) < r_prod) ? S_RDA : S_EMIT;
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_kind;
    assign o_accepted        = r_acc;
    assign o_out_sample      = r_sample;
    assign o_channel         = r_ch;
    assign o_interpolated    = r_interp;
    assign o_frames_produced = r_oprod;
    assign o_fill_level      = r_ofill;
    assign o_target_level    = r_otgt;
    assign o_overrun_count   = r_oovr;
    assign o_underrun_count  = r_ound;
    assign o_last            = r_last;
endmodule

FILE: rtl/core/frl_checker.sv
`include "assert_macros.svh"

module frl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_result_kind,
    input logic                          o_accepted,
    input frl_pkg::t_sample              o_out_sample,
    input logic                          o_interpolated,
    input logic [frl_pkg::NFR_W-1:0]     o_frames_produced,
    input logic                          o_last
);
    // A push acknowledgement is always the only and final result.
    `ASSERT_IMPL(a_push_last, i_clk, i_rst_n, o_out_valid && !o_result_kind, o_last)
    // Zero fill and push results carry no sample.
    `ASSERT_IMPL(a_zero_fill, i_clk, i_rst_n, o_out_valid && !o_interpolated, o_out_sample == '0)
    // Pulled samples never claim a stored push.
    `ASSERT_IMPL(a_pull_acc, i_clk, i_rst_n, o_out_valid && o_result_kind, !o_accepted)
    // The produced count only appears on the final result.
    `ASSERT_IMPL(a_prod_last, i_clk, i_rst_n, o_out_valid && !o_last, o_frames_produced == '0)
    // A stalled result stays in place.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
                 o_out_valid && $stable(o_out_sample))
endmodule

bind fifo_linear_resampler frl_checker u_frl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_result_kind     (o_result_kind),
    .o_accepted        (o_accepted),
    .o_out_sample      (o_out_sample),
    .o_interpolated    (o_interpolated),
    .o_frames_produced (o_frames_produced),
    .o_last            (o_last)
);

FILE: bench/fifo_linear_resampler_tb.sv
`timescale 1ns / 1ps

module fifo_linear_resampler_tb;
    import frl_pkg::*;

    typedef struct {
        logic                   kind;
        logic                   accepted;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   channel;
        logic                   interp;
        logic [NFR_W-1:0]       produced;
        logic [FILL_W-1:0]      fill;
        logic [FILL_W-1:0]      target;
        logic [CNT_W-1:0]       overruns;
        logic [CNT_W-1:0]       underruns;
        logic                   last;
    } resample_result_t;

    class resampler_scoreboard;
        logic [FRAME_W-1:0] ring [RING_DEPTH];
        int unsigned rd_ptr, wr_ptr, fill, phase, overruns, underruns;
        int unsigned capacity, target, channels;
        resample_result_t pending_results [$];
        int errors;

        function void clear_ring();
            foreach (ring[i]) ring[i] = '0;
            rd_ptr = 0;
            wr_ptr = 0;
            fill = 0;
            phase = 0;
            overruns = 0;
            underruns = 0;
        endfunction

        function void reset_state();
            capacity = RING_DEPTH;
            target = 0;
            channels = 2;
            errors = 0;
            clear_ring();
        endfunction

        function void write_reg(logic [1:0] idx, logic [FILL_W-1:0] data);
            if (idx == CFG_CAPACITY) begin
                capacity = (data < 2) ? 2 : (data > RING_DEPTH) ? RING_DEPTH : data;
                clear_ring();
            end else if (idx == CFG_TARGET) begin
                target = data;
            end else if (idx == CFG_CHANNELS) begin
                channels = (data < 1) ? 1 : (data > MAX_CHANNELS) ? MAX_CHANNELS : data;
                clear_ring();
            end
        endfunction

        function longint stored_sample(int unsigned offset, int unsigned ch);
            int unsigned p;
            logic [FRAME_W-1:0] frame;
            p = rd_ptr + offset;
            if (p >= capacity) p -= capacity;
            if (p >= RING_DEPTH) p = 0;
            frame = ring[p];
            return ch ? longint'($signed(frame[2*SAMPLE_BITS-1:SAMPLE_BITS]))
                      : longint'($signed(frame[SAMPLE_BITS-1:0]));
        endfunction

        function void add_result(logic kind, logic acc, longint s, int unsigned ch,
                                 logic ip, int unsigned prod, logic lst);
            resample_result_t r;
            r.kind = kind;
            r.accepted = acc;
            r.sample = s[SAMPLE_BITS-1:0];
            r.channel = ch[0];
            r.interp = ip;
            r.produced = prod[NFR_W-1:0];
            r.fill = fill[FILL_W-1:0];
            r.target = (target < capacity) ? target : capacity;
            r.overruns = overruns;
            r.underruns = underruns;
            r.last = lst;
            pending_results.push_back(r);
        endfunction

        function void note_request(logic req, logic [SAMPLE_BITS-1:0] s0,
                                   logic [SAMPLE_BITS-1:0] s1,
                                   logic [NFR_W-1:0] fc, logic [RATIO_W-1:0] ratio);
            int unsigned n, produced, need, rd, endp, pos, idx, frac, cons_pos, consume;
            int unsigned w;
            longint a, b;
            longint samp [MAX_PULL_FRAMES][MAX_CHANNELS];
            logic ok;
            if (req == REQ_PUSH) begin
                ok = fill < capacity;
                if (ok) begin
                    w = (wr_ptr < RING_DEPTH) ? wr_ptr : 0;
                    ring[w] = {s1, s0};
                    w++;
                    if (w >= capacity) w = 0;
                    wr_ptr = w;
                    fill++;
                end else begin
                    overruns++;
                end
                add_result(1'b0, ok, 0, 0, 1'b0, 0, 1'b1);
                return;
            end
            n = (fc > MAX_PULL_FRAMES) ? MAX_PULL_FRAMES : fc;
            produced = 0;
            if (ratio == 0) begin
                underruns++;
            end else begin
                endp = phase + n * ratio;
                need = (endp >> 16) + 2;
                if (need > capacity) need = capacity;
                rd = (need < fill) ? need : fill;
                if (rd < 2) begin
                    underruns++;
                end else begin
                    while (produced < n) begin
                        pos = phase + produced * ratio;
                        if (pos >= ((rd - 1) << 16)) break;
                        idx = pos >> 16;
                        frac = pos & 16'hFFFF;
                        for (int c = 0; c < channels; c++) begin
                            a = stored_sample(idx, c);
                            b = stored_sample(idx + 1, c);
                            // Arithmetic shift floors toward minus infinity.
                            samp[produced][c] = a + (((b - a) * longint'(frac)) >>> 16);
                        end
                        produced++;
                    end
                    if (produced < n) underruns++;
                    cons_pos = phase + produced * ratio;
                    consume = cons_pos >> 16;
                    if (consume > rd) consume = rd;
                    rd_ptr += consume;
                    if (rd_ptr >= capacity) rd_ptr -= capacity;
                    fill -= consume;
                    phase = (cons_pos - (consume << 16)) & 32'h00FF_FFFF;
                end
            end
            if (n == 0) begin
                add_result(1'b1, 1'b0, 0, 0, 1'b0, 0, 1'b1);
                return;
            end
            for (int f = 0; f < n; f++) begin
                for (int c = 0; c < channels; c++) begin
                    if (f == n - 1 && c == channels - 1)
                        add_result(1'b1, 1'b0, (f < produced) ? samp[f][c] : 0, c,
                                   f < produced, produced, 1'b1);
                    else
                        add_result(1'b1, 1'b0, (f < produced) ? samp[f][c] : 0, c,
                                   f < produced, 0, 1'b0);
                end
            end
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(resample_result_t act);
            resample_result_t e;
            if (pending_results.size() == 0) begin
                $error("result arrived with nothing outstanding");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            compare_field("result_kind", e.kind, act.kind);
            compare_field("accepted", e.accepted, act.accepted);
            compare_field("out_sample", $signed(e.sample), $signed(act.sample));
            compare_field("channel", e.channel, act.channel);
            compare_field("interpolated", e.interp, act.interp);
            compare_field("frames_produced", e.produced, act.produced);
            compare_field("fill_level", e.fill, act.fill);
            compare_field("target_level", e.target, act.target);
            compare_field("overrun_count", e.overruns, act.overruns);
            compare_field("underrun_count", e.underruns, act.underruns);
            compare_field("last", e.last, act.last);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index;
    logic [FILL_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_req_type;
    t_sample              i_sample_0;
    t_sample              i_sample_1;
    logic [NFR_W-1:0]     i_frame_count;
    logic [RATIO_W-1:0]   i_ratio;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_result_kind;
    logic                 o_accepted;
    t_sample              o_out_sample;
    logic                 o_channel;
    logic                 o_interpolated;
    logic [NFR_W-1:0]     o_frames_produced;
    logic [FILL_W-1:0]    o_fill_level;
    logic [FILL_W-1:0]    o_target_level;
    logic [CNT_W-1:0]     o_overrun_count;
    logic [CNT_W-1:0]     o_underrun_count;
    logic                 o_last;

    fifo_linear_resampler DUT (.*);

    resampler_scoreboard sb;
    bit quiet_phase;
    int stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Receiver stalls in random bursts until the quiet tail of the run.
    initial begin
        i_out_stall = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (quiet_phase) begin
                i_out_stall = 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                stall_left = $urandom_range(0, 7);
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        resample_result_t act;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            act.kind = o_result_kind;
            act.accepted = o_accepted;
            act.sample = o_out_sample;
            act.channel = o_channel;
            act.interp = o_interpolated;
            act.produced = o_frames_produced;
            act.fill = o_fill_level;
            act.target = o_target_level;
            act.overruns = o_overrun_count;
            act.underruns = o_underrun_count;
            act.last = o_last;
            sb.check_result(act);
        end
    end

    task automatic send_request(logic req, logic [SAMPLE_BITS-1:0] s0,
                                logic [SAMPLE_BITS-1:0] s1,
                                logic [NFR_W-1:0] fc, logic [RATIO_W-1:0] ratio);
        int gap;
        @(negedge i_clk);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_req_type = req;
        i_sample_0 = s0;
        i_sample_1 = s1;
        i_frame_count = fc;
        i_ratio = ratio;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req, s0, s1, fc, ratio);
    endtask

    task automatic push_frame(logic [SAMPLE_BITS-1:0] s0, logic [SAMPLE_BITS-1:0] s1);
        send_request(REQ_PUSH, s0, s1, NFR_W'($urandom()), RATIO_W'($urandom()));
    endtask

    task automatic pull_block(logic [NFR_W-1:0] fc, logic [RATIO_W-1:0] ratio);
        send_request(REQ_PULL, SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()), fc, ratio);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [FILL_W-1:0] data);
        drain_results();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_ratio(output logic [RATIO_W-1:0] r);
        case ($urandom_range(0, 9))
            0: r = RATIO_W'($urandom());
            1: r = RATIO_W'($urandom_range(1, 255));
            2: r = 20'h10000;
            default: r = RATIO_W'($urandom_range(20'h04000, 20'h24000));
        endcase
    endtask

    task automatic random_traffic(int count);
        logic [RATIO_W-1:0] r;
        for (int i = 0; i < count; i++) begin
            random_ratio(r);
            if ($urandom_range(0, 9) < 6)
                push_frame(SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()));
            else if ($urandom_range(0, 9) == 0)
                pull_block(NFR_W'($urandom_range(0, 31)), r);
            else
                pull_block(NFR_W'($urandom_range(1, 6)), r);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        quiet_phase = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CAPACITY;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_req_type = REQ_PUSH;
        i_sample_0 = '0;
        i_sample_1 = '0;
        i_frame_count = '0;
        i_ratio = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pulls from an empty ring, invalid ratio, zero and oversized counts.
        pull_block(5'd4, 20'h10000);
        pull_block(5'd3, 20'd0);
        pull_block(5'd0, 20'd0);
        push_frame(24'h7FFFFF, 24'h800000);
        pull_block(5'd2, 20'h08000);
        push_frame(24'h800000, 24'h7FFFFF);
        push_frame(24'h000000, 24'hFFFFFF);
        push_frame(24'hFFFFFF, 24'h000001);
        pull_block(5'd0, 20'h10000);
        pull_block(5'd31, 20'h00001);
        pull_block(5'd3, 20'h0C000);
        pull_block(5'd16, 20'hFFFFF);
        write_register(CFG_TARGET, 11'd2047);
        write_register(CFG_CAPACITY, 11'd0);
        push_frame(24'h123456, 24'h654321);
        push_frame(24'hABCDEF, 24'h000000);
        push_frame(24'h111111, 24'h222222);
        pull_block(5'd2, 20'h18000);
        write_register(CFG_CHANNELS, 11'd0);
        write_register(CFG_TARGET, 11'd0);
        push_frame(24'h400000, 24'h0);
        push_frame(24'hC00000, 24'h0);
        pull_block(5'd17, 20'h02000);

        write_register(CFG_CAPACITY, 11'd2047);
        write_register(CFG_CHANNELS, 11'd3);
        write_register(CFG_TARGET, 11'd512);
        random_traffic(60);

        write_register(CFG_CAPACITY, 11'd6);
        write_register(CFG_CHANNELS, 11'd1);
        random_traffic(50);
        drain_results();

        write_register(CFG_CAPACITY, 11'd24);
        write_register(CFG_CHANNELS, 11'd2);
        write_register(CFG_TARGET, 11'd1024);
        random_traffic(70);

        write_register(CFG_CAPACITY, 11'd1024);
        write_register(CFG_TARGET, 11'd7);
        quiet_phase = 1'b1;
        random_traffic(50);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/frl_pkg.sv
rtl/core/frl_ram.sv
rtl/core/frl_interp.sv
rtl/core/fifo_linear_resampler.sv
rtl/core/frl_checker.sv
bench/fifo_linear_resampler_tb.sv
